// ----- sv/cgnt_pkg.sv -----
// Shared types and constants for the Canny thinning and threshold block.
package cgnt_pkg;

    localparam int CNT_W    = 12;
    localparam int CFG_W    = 11;
    localparam int SUMSQ_W  = 22;
    localparam int DATA_W   = 11;
    localparam int MAG_W    = 8;
    localparam int IDX_W    = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [MAG_W-1:0] RST_LOW_THR  = 8'd100;
    localparam logic [MAG_W-1:0] RST_HIGH_THR = 8'd200;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_THR  = 2'd0,
        REG_HIGH_THR = 2'd1,
        REG_WIDTH    = 2'd2,
        REG_HEIGHT   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEC_HORZ     = 2'd0,
        SEC_VERT     = 2'd1,
        SEC_DIAG_SAME = 2'd2,
        SEC_DIAG_OPP = 2'd3
    } t_sector;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SUMSQ_W-1:0] sumsq;
        t_sector            dir;
    } t_item;

    typedef struct packed {
        logic [MAG_W-1:0] center;
        logic [MAG_W-1:0] above;
        t_sector          dir;
    } t_line;

    typedef struct packed {
        logic [MAG_W-1:0] low_thr;
        logic [MAG_W-1:0] high_thr;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

endpackage

// ----- sv/canny_gradient_nms_threshold.sv -----
// Top level of the Canny gradient thinning and double threshold block.
// In the back end each derivative beat passes, in order, through popping the
// queue and reading the line store, the bit-serial square root, and then
// suppression, classification and line store write-back;
// the square root iteration sets the item rate. A two-entry queue sits between
// the front end and the back end, and a result register lets the back end finish
// the next item while a result waits. Results trail the input by frame_width+1
// beats; frame_width+1 padding beats after the last pixel flush the frame.
// Register writes are accepted every cycle.
module canny_gradient_nms_threshold
    import cgnt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_deriv_x,
    input  logic signed [DATA_W-1:0] i_deriv_y,
    input  logic                     i_padding,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [MAG_W-1:0]         o_thinned_magnitude,
    output logic [1:0]               o_edge_class,
    output logic                     o_end_of_frame,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int top);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < CFG_W'(3)) begin
            res = CFG_W'(3);
        end else if (32'(v) > 32'(top)) begin
            res = CFG_W'(top);
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= RST_LOW_THR;
            r_cfg.high_thr <= RST_HIGH_THR;
            r_cfg.width    <= clamp_size(CFG_W'(1024), MAX_WIDTH);
            r_cfg.height   <= clamp_size(CFG_W'(1024), MAX_HEIGHT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LOW_THR:  r_cfg.low_thr  <= i_cfg_data[MAG_W-1:0];
                REG_HIGH_THR: r_cfg.high_thr <= i_cfg_data[MAG_W-1:0];
                REG_WIDTH:    r_cfg.width    <= clamp_size(i_cfg_data, MAX_WIDTH);
                REG_HEIGHT:   r_cfg.height   <= clamp_size(i_cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    cgnt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_deriv_x (i_deriv_x),
        .i_deriv_y (i_deriv_y),
        .i_padding (i_padding),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    cgnt_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_thinned_magnitude (o_thinned_magnitude),
        .o_edge_class        (o_edge_class),
        .o_end_of_frame      (o_end_of_frame)
    );

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_edge_class != 2'd3))
        else $error("edge class out of range");

    a_strong_above_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edge_class == CLS_STRONG) |-> (o_thinned_magnitude > r_cfg.high_thr))
        else $error("strong edge not above high threshold");

    a_none_below_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edge_class == CLS_NONE) |-> (o_thinned_magnitude < r_cfg.low_thr))
        else $error("non-edge not below low threshold");

endmodule

// ----- sv/cgnt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cgnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cgnt_front.sv -----
// Front end: takes derivative beats, forms squared magnitude and sector, queues them.
module cgnt_front
    import cgnt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_deriv_x,
    input  logic signed [DATA_W-1:0] i_deriv_y,
    input  logic                     i_padding,
    output logic                     o_q_valid,
    output t_item                    o_q_item,
    input  logic                     i_q_pop
);

    logic signed [DATA_W-1:0] x, y;
    logic [DATA_W-1:0]  ax, ay;
    logic [SUMSQ_W-1:0] ax_w, ay_w;
    logic [SUMSQ_W-1:0] ay256, ax106, ax618;
    t_item              item;
    logic               push;

    t_item      r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    always_comb begin
        x     = i_padding ? '0 : i_deriv_x;
        y     = i_padding ? '0 : i_deriv_y;
        ax    = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
        ay    = y[DATA_W-1] ? DATA_W'(-y) : DATA_W'(y);
        ax_w  = SUMSQ_W'(ax);
        ay_w  = SUMSQ_W'(ay);
        ay256 = ay_w << 8;
        ax106 = SUMSQ_W'(ax_w * SUMSQ_W'(106));
        ax618 = SUMSQ_W'(ax_w * SUMSQ_W'(618));
        item.sumsq = SUMSQ_W'(ax_w * ax_w) + SUMSQ_W'(ay_w * ay_w);
        if (ay256 <= ax106) begin
            item.dir = SEC_HORZ;
        end else if (ay256 >= ax618) begin
            item.dir = SEC_VERT;
        end else if ((x > 0) == (y > 0)) begin
            item.dir = SEC_DIAG_SAME;
        end else begin
            item.dir = SEC_DIAG_OPP;
        end
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ----- sv/cgnt_back.sv -----
// Back end: square root, line stores, 3x3 window, suppression and classification.
module cgnt_back
    import cgnt_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [MAG_W-1:0] o_thinned_magnitude,
    output logic [1:0]       o_edge_class,
    output logic             o_end_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);

    t_state             r_state, n_state;
    logic [SUMSQ_W-1:0] r_sumsq;
    t_sector            r_dir;
    logic [MAG_W-1:0]   r_root;
    logic [2:0]         r_bit;
    logic [CNT_W-1:0]   r_col, r_row, n_col, n_row;
    logic [MAG_W-1:0]   r_win [9];
    logic [MAG_W-1:0]   n_win [9];
    t_sector            r_dir_dly;
    logic [MAG_W-1:0]   r_out_mag;
    t_class             r_out_cls;
    logic               r_out_eof, r_out_valid;

    logic               out_free, pop, step, emit;
    logic [MAG_W-1:0]   try_root, mag, m, nb_a, nb_b;
    logic [2*MAG_W-1:0] try_sq;
    t_line              rd, wr;
    logic [CNT_W-1:0]   w, h, cr, cc, c1, r1;
    logic               vld, eof, inner;
    t_class             cls;

    assign w = CNT_W'(i_cfg.width);
    assign h = CNT_W'(i_cfg.height);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_ROOT;
            ST_ROOT: if (r_bit == 3'd0) n_state = ST_EMIT;
            ST_EMIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        pop  = (r_state == ST_IDLE) && i_q_valid;
        step = (r_state == ST_ROOT);
        emit = (r_state == ST_EMIT) && out_free;
    end

    assign o_q_pop = pop;

    cgnt_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (emit),
        .i_waddr (r_col[AW-1:0]),
        .i_wdata (wr),
        .i_re    (pop),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (rd)
    );

    always_comb begin
        try_root = r_root | (8'd1 << r_bit);
        try_sq   = {8'b0, try_root} * {8'b0, try_root};
        mag      = (r_sumsq >= SUMSQ_W'(65536)) ? 8'hFF : r_root;
        wr.center = mag;
        wr.above  = rd.center;
        wr.dir    = r_dir;

        n_win[0] = r_win[1]; n_win[1] = r_win[2]; n_win[2] = rd.above;
        n_win[3] = r_win[4]; n_win[4] = r_win[5]; n_win[5] = rd.center;
        n_win[6] = r_win[7]; n_win[7] = r_win[8]; n_win[8] = mag;

        if (r_col != '0) begin
            vld = (r_row >= CNT_W'(1));
            cr  = r_row - CNT_W'(1);
            cc  = r_col - CNT_W'(1);
        end else begin
            vld = (r_row >= CNT_W'(2));
            cr  = r_row - CNT_W'(2);
            cc  = w - CNT_W'(1);
        end
        vld   = vld && (cr < h) && (cc < w);
        eof   = vld && (cr == h - CNT_W'(1)) && (cc == w - CNT_W'(1));
        inner = (cr != '0) && (cr != h - CNT_W'(1)) && (cc != '0) && (cc != w - CNT_W'(1));

        case (r_dir_dly)
            SEC_HORZ:      begin nb_a = n_win[3]; nb_b = n_win[5]; end
            SEC_VERT:      begin nb_a = n_win[1]; nb_b = n_win[7]; end
            SEC_DIAG_SAME: begin nb_a = n_win[8]; nb_b = n_win[0]; end
            default:       begin nb_a = n_win[2]; nb_b = n_win[6]; end
        endcase
        m = n_win[4];
        if (inner && (m < nb_a || m < nb_b)) begin
            m = '0;
        end
        if (m < i_cfg.low_thr) begin
            cls = CLS_NONE;
        end else if (m > i_cfg.high_thr) begin
            cls = CLS_STRONG;
        end else begin
            cls = CLS_WEAK;
        end

        c1 = r_col + CNT_W'(1);
        r1 = r_row;
        if (c1 >= w) begin
            c1 = '0;
            r1 = r_row + CNT_W'(1);
        end
        if (eof || r1 > h + CNT_W'(1)) begin
            c1 = '0;
            r1 = '0;
        end
        n_col = c1;
        n_row = r1;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sumsq <= (r_row < h) ? i_q_item.sumsq : '0;
            r_dir   <= (r_row < h) ? i_q_item.dir : SEC_HORZ;
            r_root  <= '0;
            r_bit   <= 3'd7;
        end else if (step) begin
            if (SUMSQ_W'(try_sq) <= r_sumsq) begin
                r_root <= try_root;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (emit) begin
            r_out_mag <= m;
            r_out_cls <= cls;
            r_out_eof <= eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_dir_dly   <= SEC_HORZ;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_dir_dly <= rd.dir;
                for (int i = 0; i < 9; i++) begin
                    r_win[i] <= n_win[i];
                end
                r_out_valid <= vld;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_thinned_magnitude = r_out_mag;
    assign o_edge_class        = r_out_cls;
    assign o_end_of_frame      = r_out_eof;

endmodule
